// ===== hdl/fwqe_pkg.sv =====
// Shared types and constants for the futex wait-queue engine.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package fwqe_pkg;

  localparam int unsigned ADDR_W = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned TID_W = 16;
  localparam int unsigned DONE_W = 6;

  typedef enum logic [1:0] {
    CMD_WAIT    = 2'd0,
    CMD_WAKE    = 2'd1,
    CMD_REQUEUE = 2'd2,
    CMD_FINISH  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_TIMEOUT  = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } op_e;

  typedef struct packed {
    op_e               op;
    logic              chk_thread;
    logic [ADDR_W-1:0] key_addr;
    logic [ADDR_W-1:0] dest_addr;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/fwqe_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
// Depends on fwqe_pkg for the field widths.
`default_nettype none

interface fwqe_in_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 cmd;
  logic [fwqe_pkg::ADDR_W-1:0] word_address;
  logic [fwqe_pkg::ADDR_W-1:0] target_address;
  logic [fwqe_pkg::TID_W-1:0]  thread_id;
  logic [fwqe_pkg::WORD_W-1:0] amount;
  logic [fwqe_pkg::WORD_W-1:0] requeue_limit;
  logic [fwqe_pkg::WORD_W-1:0] compare_value;
  logic [fwqe_pkg::WORD_W-1:0] current_word;

  modport source (
    output valid, cmd, word_address, target_address, thread_id, amount,
           requeue_limit, compare_value, current_word,
    input  ready
  );
  modport sink (
    input  valid, cmd, word_address, target_address, thread_id, amount,
           requeue_limit, compare_value, current_word,
    output ready
  );
endinterface

interface fwqe_out_if;
  logic                        valid;
  logic                        ready;
  logic [fwqe_pkg::TID_W-1:0]  woken_thread;
  logic [1:0]                  status;
  logic [fwqe_pkg::DONE_W-1:0] done_count;
  logic                        last;

  modport source (
    output valid, woken_thread, status, done_count, last,
    input  ready
  );
  modport sink (
    input  valid, woken_thread, status, done_count, last,
    output ready
  );
endinterface

`default_nettype wire

// ===== hdl/fwqe_cell.sv =====
// One slot of the compacted waiter table: holds an entry, matches it against the
// command key and shifts or rotates with its neighbors. Depends on fwqe_pkg.
`default_nettype none

module fwqe_cell #(
  parameter int unsigned TID_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire fwqe_pkg::ctrl_t               ctrl_i,
  input  wire logic [TID_BITS-1:0]           key_thread_i,
  input  wire logic                          prv_valid_i,
  input  wire logic                          nxt_valid_i,
  input  wire logic                          nxt_moved_i,
  input  wire logic [fwqe_pkg::ADDR_W-1:0]   nxt_addr_i,
  input  wire logic [TID_BITS-1:0]           nxt_thread_i,
  input  wire logic                          found_i,
  input  wire logic [TID_BITS-1:0]           carry_thread_i,
  output logic                               valid_o,
  output logic                               moved_o,
  output logic [fwqe_pkg::ADDR_W-1:0]        addr_o,
  output logic [TID_BITS-1:0]                thread_o,
  output logic                               found_o,
  output logic [TID_BITS-1:0]                carry_thread_o
);

  logic                        valid_q, valid_d;
  logic                        moved_q, moved_d;
  logic [fwqe_pkg::ADDR_W-1:0] addr_q, addr_d;
  logic [TID_BITS-1:0]         thread_q, thread_d;
  logic                        hit;
  logic                        is_last;

  assign hit = valid_q && !moved_q && (addr_q == ctrl_i.key_addr) &&
               (!ctrl_i.chk_thread || (thread_q == key_thread_i));
  assign found_o = found_i || hit;
  assign carry_thread_o = found_i ? carry_thread_i : thread_q;
  assign is_last = valid_q && !nxt_valid_i;

  always_comb begin
    valid_d  = valid_q;
    moved_d  = 1'b0;
    addr_d   = addr_q;
    thread_d = thread_q;
    unique case (ctrl_i.op)
      fwqe_pkg::OP_APPEND: begin
        if (!valid_q && prv_valid_i) begin
          valid_d  = 1'b1;
          addr_d   = ctrl_i.key_addr;
          thread_d = key_thread_i;
        end
      end
      fwqe_pkg::OP_REMOVE: begin
        if (found_o) begin
          valid_d  = nxt_valid_i;
          addr_d   = nxt_addr_i;
          thread_d = nxt_thread_i;
        end
      end
      fwqe_pkg::OP_ROTATE: begin
        moved_d = moved_q;
        if (found_o) begin
          if (is_last) begin
            addr_d   = ctrl_i.dest_addr;
            thread_d = carry_thread_o;
            moved_d  = 1'b1;
          end else begin
            valid_d  = nxt_valid_i;
            addr_d   = nxt_addr_i;
            thread_d = nxt_thread_i;
            moved_d  = nxt_moved_i;
          end
        end
      end
      default: begin
        moved_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      moved_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      moved_q <= moved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    thread_q <= thread_d;
  end

  assign valid_o  = valid_q;
  assign moved_o  = moved_q;
  assign addr_o   = addr_q;
  assign thread_o = thread_q;

endmodule

`default_nettype wire

// ===== hdl/futex_wait_queue_engine_core.sv =====
// Futex wait-queue engine: command sequencer, result register and the row of table cells.
// The summary beat ends every command; before it, a wake releases w waiters (one result
// beat per cycle while the result register is free) and a compare-requeue that matches
// also requeues r (one per cycle); w + r is at most QUEUE_DEPTH. One command is in flight
// at a time; the next is accepted the cycle after the summary is stored. Reset empties
// the table at once.
`default_nettype none

module futex_wait_queue_engine_core #(
  parameter int unsigned QUEUE_DEPTH    = 32,
  parameter int unsigned THREAD_ID_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fwqe_in_if.sink    in_i,
  fwqe_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WAKE,
    S_REQ,
    S_SUM
  } state_e;

  state_e                        state_q;
  fwqe_pkg::cmd_e                cmd_q;
  fwqe_pkg::status_e             status_q;
  logic [fwqe_pkg::ADDR_W-1:0]   addr_q;
  logic [fwqe_pkg::ADDR_W-1:0]   dest_q;
  logic [THREAD_ID_BITS-1:0]     tid_q;
  logic [fwqe_pkg::WORD_W-1:0]   limit_q;
  logic [fwqe_pkg::WORD_W-1:0]   rq_q;
  logic                          mism_q;
  logic [CntW-1:0]               cnt_q;
  logic [CntW-1:0]               done_q;

  logic                          out_valid_q;
  logic [fwqe_pkg::TID_W-1:0]    out_thread_q;
  fwqe_pkg::status_e             out_status_q;
  logic [fwqe_pkg::DONE_W-1:0]   out_done_q;
  logic                          out_last_q;

  fwqe_pkg::ctrl_t               ctrl;
  logic                          out_free;
  logic                          out_load;
  logic                          full;
  logic                          wake_more;
  logic                          req_more;

  logic [QUEUE_DEPTH-1:0]        vld;
  logic [QUEUE_DEPTH-1:0]        mov;
  logic [fwqe_pkg::ADDR_W-1:0]   adr [QUEUE_DEPTH];
  logic [THREAD_ID_BITS-1:0]     thr [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]          fnd;
  logic [THREAD_ID_BITS-1:0]     cth [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0]        vld_inc;

  assign fnd[0] = 1'b0;
  assign cth[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic                        prv_valid;
    logic                        nxt_valid;
    logic                        nxt_moved;
    logic [fwqe_pkg::ADDR_W-1:0] nxt_addr;
    logic [THREAD_ID_BITS-1:0]   nxt_thread;

    if (i == 0) begin : g_head
      assign prv_valid = 1'b1;
    end else begin : g_body
      assign prv_valid = vld[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign nxt_valid  = 1'b0;
      assign nxt_moved  = 1'b0;
      assign nxt_addr   = '0;
      assign nxt_thread = '0;
    end else begin : g_link
      assign nxt_valid  = vld[i+1];
      assign nxt_moved  = mov[i+1];
      assign nxt_addr   = adr[i+1];
      assign nxt_thread = thr[i+1];
    end

    fwqe_cell #(
      .TID_BITS(THREAD_ID_BITS)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .ctrl_i         (ctrl),
      .key_thread_i   (tid_q),
      .prv_valid_i    (prv_valid),
      .nxt_valid_i    (nxt_valid),
      .nxt_moved_i    (nxt_moved),
      .nxt_addr_i     (nxt_addr),
      .nxt_thread_i   (nxt_thread),
      .found_i        (fnd[i]),
      .carry_thread_i (cth[i]),
      .valid_o        (vld[i]),
      .moved_o        (mov[i]),
      .addr_o         (adr[i]),
      .thread_o       (thr[i]),
      .found_o        (fnd[i+1]),
      .carry_thread_o (cth[i+1])
    );
  end

  assign full      = vld[QUEUE_DEPTH-1];
  assign out_free  = !out_valid_q || out_o.ready;
  assign wake_more = fnd[QUEUE_DEPTH] && (fwqe_pkg::WORD_W'(cnt_q) < limit_q);
  assign req_more  = fnd[QUEUE_DEPTH] && (fwqe_pkg::WORD_W'(cnt_q) < rq_q);
  assign vld_inc   = vld + QUEUE_DEPTH'(1);
  assign out_load  = ((state_q == S_WAKE) && wake_more && out_free) ||
                     ((state_q == S_SUM) && out_free);

  always_comb begin
    ctrl.key_addr   = addr_q;
    ctrl.dest_addr  = dest_q;
    ctrl.chk_thread = (state_q == S_DECODE) && (cmd_q == fwqe_pkg::CMD_FINISH);
    ctrl.op         = fwqe_pkg::OP_NONE;
    unique case (state_q)
      S_DECODE: begin
        if (cmd_q == fwqe_pkg::CMD_WAIT && !mism_q && !full) begin
          ctrl.op = fwqe_pkg::OP_APPEND;
        end else if (cmd_q == fwqe_pkg::CMD_FINISH) begin
          ctrl.op = fwqe_pkg::OP_REMOVE;
        end
      end
      S_WAKE: begin
        if (wake_more && out_free) begin
          ctrl.op = fwqe_pkg::OP_REMOVE;
        end
      end
      S_REQ: begin
        if (req_more) begin
          ctrl.op = fwqe_pkg::OP_ROTATE;
        end
      end
      default: begin
        ctrl.op = fwqe_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cmd_q        <= fwqe_pkg::CMD_WAIT;
      status_q     <= fwqe_pkg::ST_OK;
      addr_q       <= '0;
      dest_q       <= '0;
      tid_q        <= '0;
      limit_q      <= '0;
      rq_q         <= '0;
      mism_q       <= 1'b0;
      cnt_q        <= '0;
      done_q       <= '0;
      out_valid_q  <= 1'b0;
      out_thread_q <= '0;
      out_status_q <= fwqe_pkg::ST_OK;
      out_done_q   <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q    <= fwqe_pkg::cmd_e'(in_i.cmd);
            addr_q   <= in_i.word_address;
            dest_q   <= in_i.target_address;
            tid_q    <= THREAD_ID_BITS'(in_i.thread_id);
            limit_q  <= (in_i.amount == '0) ? fwqe_pkg::WORD_W'(1) : in_i.amount;
            rq_q     <= in_i.requeue_limit;
            mism_q   <= (in_i.cmd == fwqe_pkg::CMD_REQUEUE) ?
                        (in_i.current_word != in_i.compare_value) :
                        (in_i.current_word != in_i.amount);
            status_q <= fwqe_pkg::ST_OK;
            cnt_q    <= '0;
            done_q   <= '0;
            state_q  <= S_DECODE;
          end
        end
        S_DECODE: begin
          unique case (cmd_q)
            fwqe_pkg::CMD_WAIT: begin
              if (mism_q) begin
                status_q <= fwqe_pkg::ST_MISMATCH;
              end else if (full) begin
                status_q <= fwqe_pkg::ST_FULL;
              end
              state_q <= S_SUM;
            end
            fwqe_pkg::CMD_WAKE: begin
              state_q <= S_WAKE;
            end
            fwqe_pkg::CMD_REQUEUE: begin
              if (mism_q) begin
                status_q <= fwqe_pkg::ST_MISMATCH;
                state_q  <= S_SUM;
              end else begin
                state_q <= S_WAKE;
              end
            end
            default: begin
              status_q <= fnd[QUEUE_DEPTH] ? fwqe_pkg::ST_TIMEOUT : fwqe_pkg::ST_OK;
              state_q  <= S_SUM;
            end
          endcase
        end
        S_WAKE: begin
          if (wake_more) begin
            if (out_free) begin
              out_thread_q <= fwqe_pkg::TID_W'(cth[QUEUE_DEPTH]);
              out_status_q <= fwqe_pkg::ST_OK;
              out_done_q   <= '0;
              out_last_q   <= 1'b0;
              cnt_q        <= cnt_q + CntW'(1);
              done_q       <= done_q + CntW'(1);
            end
          end else begin
            cnt_q <= '0;
            if (cmd_q == fwqe_pkg::CMD_REQUEUE && rq_q != '0) begin
              state_q <= S_REQ;
            end else begin
              state_q <= S_SUM;
            end
          end
        end
        S_REQ: begin
          if (req_more) begin
            cnt_q  <= cnt_q + CntW'(1);
            done_q <= done_q + CntW'(1);
          end else begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          if (out_free) begin
            out_thread_q <= '0;
            out_status_q <= status_q;
            out_done_q   <= fwqe_pkg::DONE_W'(done_q);
            out_last_q   <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.woken_thread = out_thread_q;
  assign out_o.status       = out_status_q;
  assign out_o.done_count   = out_done_q;
  assign out_o.last         = out_last_q;

  a_no_append_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.op == fwqe_pkg::OP_APPEND) |-> !full)
    else $error("Append issued while the table is full.");

  a_table_compacted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_inc & vld) == '0))
    else $error("Valid entries do not form a prefix of the table.");

  a_summary_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM && out_free) |=> (out_o.valid && out_o.last && state_q == S_IDLE))
    else $error("Summary beat was not stored when the result register was free.");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fwqe_pkg::WORD_W'(cnt_q) <= fwqe_pkg::WORD_W'(QUEUE_DEPTH)))
    else $error("Per-phase count exceeds the table depth.");

  a_release_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAKE && ctrl.op == fwqe_pkg::OP_REMOVE) |=>
      (out_o.valid && !out_o.last))
    else $error("A released waiter did not produce a result beat.");

endmodule

`default_nettype wire
